// ===== hdl/script_byte_tokenizer_core_macros.svh =====
// assertion helpers shared by the tokenizer modules
`ifndef SCRIPT_BYTE_TOKENIZER_CORE_MACROS_SVH
`define SCRIPT_BYTE_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication
`define SBT_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sbt_pkg.sv =====
`default_nettype none

package sbt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int NUM_KW = 17;

   // token kinds
   localparam logic [5:0] KIND_EOF       = 6'd0;
   localparam logic [5:0] KIND_INT       = 6'd1;
   localparam logic [5:0] KIND_FLOAT     = 6'd2;
   localparam logic [5:0] KIND_STRING    = 6'd3;
   localparam logic [5:0] KIND_IDENT     = 6'd4;
   localparam logic [5:0] KIND_DIALOGUES = 6'd5;
   localparam logic [5:0] KIND_LINES     = 6'd14;
   localparam logic [5:0] KIND_LBRACE    = 6'd21;
   localparam logic [5:0] KIND_RBRACE    = 6'd22;
   localparam logic [5:0] KIND_LBRACKET  = 6'd23;
   localparam logic [5:0] KIND_RBRACKET  = 6'd24;
   localparam logic [5:0] KIND_PLUS      = 6'd25;
   localparam logic [5:0] KIND_MINUS     = 6'd26;
   localparam logic [5:0] KIND_STAR      = 6'd27;
   localparam logic [5:0] KIND_SLASH     = 6'd28;
   localparam logic [5:0] KIND_ASSIGN    = 6'd29;
   localparam logic [5:0] KIND_LPAREN    = 6'd30;
   localparam logic [5:0] KIND_RPAREN    = 6'd31;
   localparam logic [5:0] KIND_COMMA     = 6'd32;
   localparam logic [5:0] KIND_SEMI      = 6'd33;

   // keyword text, right aligned, first char in the highest used byte
   localparam logic [79:0] KW_TEXT [NUM_KW] = '{
      "DIALOGUES", "auto", "interact", "id", "next", "once", "rect", "speaker",
      "sprite", "lines", "int", "float", "string", "bool", "true", "false", "SAY"
   };
   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd9, 4'd4, 4'd8, 4'd2, 4'd4, 4'd4, 4'd4, 4'd7, 4'd6, 4'd5, 4'd3, 4'd5,
      4'd6, 4'd4, 4'd4, 4'd5, 4'd3
   };
   localparam logic [5:0] KW_KIND [NUM_KW] = '{
      6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20
   };

   typedef struct packed {
      logic [7:0] source_byte;
      logic       byte_present;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic        from_engine;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   // tokens caused by one input beat
   typedef struct packed {
      rsp_type [2:0] tok;
      logic [1:0]    count;
   } tok_group_type;

   function automatic logic [7:0] kw_char(input int k, input logic [3:0] idx);
      logic [3:0] r;
      r = KW_LEN[k] - 4'd1 - idx;
      return KW_TEXT[k][{r, 3'b000} +: 8];
   endfunction

   function automatic logic engine_flag(input logic [5:0] kind);
      return (kind >= KIND_DIALOGUES && kind <= KIND_LINES) ||
             (kind >= KIND_LBRACE && kind <= KIND_RBRACKET);
   endfunction

   function automatic logic [5:0] symbol_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "[":     k = KIND_LBRACKET;
         "]":     k = KIND_RBRACKET;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "=":     k = KIND_ASSIGN;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/script_byte_tokenizer_core.sv =====
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | req_data (req_type)
// rsp     | out       | rsp_valid/rsp_ready | rsp_data (rsp_type)
//
// one source byte per cycle while req_ready is high; lexing and keyword match
// finish in the accept cycle; an item yielding k tokens goes out one token per beat
// the token queue holds the tokens of two items; req_ready falls while both slots are full
// synchronous active-high reset clears lexer mode, offset and queue; no clearing pass
`default_nettype none

module script_byte_tokenizer_core
   import sbt_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   tok_group_type grp;
   logic          full, accept;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   sbt_lexer #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_lexer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .grp    (grp)
   );

   sbt_tok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && grp.count != 2'd0),
      .push_grp  (grp),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/sbt_lexer.sv =====
`default_nettype none
`include "script_byte_tokenizer_core_macros.svh"

module sbt_lexer
   import sbt_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire req_type       req,
   output tok_group_type      grp
);

   localparam int OB = OFFSET_BITS;

   typedef enum logic [2:0] {
      M_IDLE, M_INT, M_INTDOT, M_FLOAT, M_STR, M_WORD
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [OB-1:0]     pos_ff, pos_in;
   logic [OB-1:0]     begin_ff, begin_in;
   logic [OB-1:0]     len_ff, len_in;
   logic [NUM_KW-1:0] alive_ff, alive_in;

   rsp_type    slot [4];
   logic [3:0] slot_v;
   logic [1:0] cnt;
   logic [7:0] c;
   logic       is_dig, is_alpha, is_ws, is_word, close, do_start;

   function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] v, input logic [1:0] n);
      logic [OB:0] s;
      s = {1'b0, v} + {{(OB-1){1'b0}}, n};
      return s[OB] ? '1 : s[OB-1:0];
   endfunction

   function automatic logic [15:0] to16(input logic [OB-1:0] v);
      logic [OB+15:0] w;
      w = {16'b0, v};
      return w[15:0];
   endfunction

   function automatic rsp_type make_tok(input logic [5:0] kind, input logic [OB-1:0] start,
                                        input logic [OB-1:0] length);
      rsp_type t;
      t.token_kind   = kind;
      t.from_engine  = engine_flag(kind);
      t.token_start  = to16(start);
      t.token_length = to16(length);
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   function automatic logic [NUM_KW-1:0] kw_track(input logic [NUM_KW-1:0] alive,
                                                  input logic [OB-1:0] idx,
                                                  input logic [7:0] ch);
      logic [NUM_KW-1:0] r;
      for (int k = 0; k < NUM_KW; k++) begin
         r[k] = alive[k] && (idx < OB'(KW_LEN[k])) && (kw_char(k, idx[3:0]) == ch);
      end
      return r;
   endfunction

   function automatic logic [5:0] word_kind(input logic [NUM_KW-1:0] alive,
                                            input logic [OB-1:0] length);
      logic [5:0] kind;
      kind = KIND_IDENT;
      // lowest matching keyword wins
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (alive[k] && length == OB'(KW_LEN[k])) kind = KW_KIND[k];
      end
      return kind;
   endfunction

   function automatic rsp_type flush_tok(input mode_type m, input logic [OB-1:0] b,
                                         input logic [OB-1:0] length,
                                         input logic [NUM_KW-1:0] alive);
      logic [5:0] kind;
      case (m)
         M_INT, M_INTDOT: kind = KIND_INT;
         M_FLOAT:         kind = KIND_FLOAT;
         M_STR:           kind = KIND_STRING;
         M_WORD:          kind = word_kind(alive, length);
         default:         kind = KIND_EOF;
      endcase
      return make_tok(kind, b, length);
   endfunction

   assign c        = req.source_byte;
   assign is_dig   = c >= "0" && c <= "9";
   assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   assign is_ws    = c == " " || c == 8'h0A || c == 8'h09 || c == 8'h0D;
   assign is_word  = is_alpha || is_dig || c == "_";

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      len_in   = len_ff;
      alive_in = alive_ff;
      slot_v   = '0;
      for (int i = 0; i < 4; i++) slot[i] = '0;
      close    = 1'b0;
      do_start = 1'b0;

      if (req.byte_present) begin
         case (mode_ff)
            M_INT: begin
               if (is_dig) len_in = sat_add(len_ff, 2'd1);
               else if (c == ".") mode_in = M_INTDOT;
               else close = 1'b1;
            end
            M_INTDOT: begin
               if (is_dig) begin
                  len_in  = sat_add(len_ff, 2'd2);
                  mode_in = M_FLOAT;
               end else close = 1'b1;
            end
            M_FLOAT: begin
               if (is_dig) len_in = sat_add(len_ff, 2'd1);
               else close = 1'b1;
            end
            M_STR: begin
               if (c == "\"") close = 1'b1;
               else len_in = sat_add(len_ff, 2'd1);
            end
            M_WORD: begin
               if (is_word) begin
                  alive_in = kw_track(alive_ff, len_ff, c);
                  len_in   = sat_add(len_ff, 2'd1);
               end else close = 1'b1;
            end
            default: do_start = 1'b1;
         endcase

         if (close) begin
            slot_v[0] = 1'b1;
            slot[0]   = flush_tok(mode_ff, begin_ff, len_ff, alive_ff);
            mode_in   = M_IDLE;
            // closing quote is consumed by the string
            do_start  = mode_ff != M_STR;
         end

         if (do_start && !is_ws) begin
            if (c == "\"") begin
               mode_in  = M_STR;
               begin_in = sat_add(pos_ff, 2'd1);
               len_in   = '0;
            end else if (is_dig) begin
               mode_in  = M_INT;
               begin_in = pos_ff;
               len_in   = OB'(1);
            end else if (is_alpha || c == "_") begin
               mode_in  = M_WORD;
               begin_in = pos_ff;
               alive_in = kw_track('1, '0, c);
               len_in   = OB'(1);
            end else if (symbol_kind(c) != KIND_EOF) begin
               slot_v[1] = 1'b1;
               slot[1]   = make_tok(symbol_kind(c), pos_ff, OB'(1));
            end
         end

         pos_in = sat_add(pos_ff, 2'd1);
      end

      if (req.end_of_source) begin
         if (mode_in != M_IDLE) begin
            slot_v[2] = 1'b1;
            slot[2]   = flush_tok(mode_in, begin_in, len_in, alive_in);
         end
         slot_v[3] = 1'b1;
         slot[3]   = make_tok(KIND_EOF, pos_in, '0);
         mode_in   = M_IDLE;
         pos_in    = '0;
         len_in    = '0;
         alive_in  = '1;
      end
   end

   // pack the valid slots in order, at most three per beat
   always_comb begin
      grp = '0;
      cnt = '0;
      for (int i = 0; i < 4; i++) begin
         if (slot_v[i] && cnt != 2'd3) begin
            grp.tok[cnt] = slot[i];
            cnt          = cnt + 2'd1;
         end
      end
      grp.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         alive_ff <= '1;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         len_ff   <= len_in;
         alive_ff <= alive_in;
      end
   end

   `SBT_ASSERT_NEXT(a_eof_rewinds, clock, reset, accept && req.end_of_source, mode_ff == M_IDLE && pos_ff == '0, "source end did not rewind lexer")
   `SBT_ASSERT_NEXT(a_pos_step, clock, reset, accept && req.byte_present && !req.end_of_source && pos_ff != '1, pos_ff == $past(pos_ff) + 1'b1, "byte offset did not advance")
   `SBT_ASSERT_IMPL(a_word_nonempty, clock, reset, mode_ff == M_WORD, len_ff != '0, "open word has zero length")

endmodule

`default_nettype wire

// ===== hdl/sbt_tok_queue.sv =====
`default_nettype none
`include "script_byte_tokenizer_core_macros.svh"

module sbt_tok_queue
   import sbt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire tok_group_type push_grp,
   output logic               full,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   tok_group_type grp_ff [2];
   tok_group_type head;
   logic [1:0]    fill_ff, fill_in;
   logic          wr_ff, rd_ff;
   logic [1:0]    sub_ff, sub_in;
   logic          last, pop_tok, pop_grp;

   assign head      = grp_ff[rd_ff];
   assign full      = fill_ff == 2'd2;
   assign rsp_valid = fill_ff != 2'd0;
   assign last      = sub_ff == head.count - 2'd1;
   assign pop_tok   = rsp_valid && rsp_ready;
   assign pop_grp   = pop_tok && last;

   always_comb begin
      rsp_data             = head.tok[sub_ff];
      rsp_data.last_of_run = last;
      fill_in              = fill_ff + {1'b0, push} - {1'b0, pop_grp};
      sub_in               = pop_grp ? 2'd0 : (pop_tok ? sub_ff + 2'd1 : sub_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         sub_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         sub_ff  <= sub_in;
         if (push) begin
            grp_ff[wr_ff] <= push_grp;
            wr_ff         <= !wr_ff;
         end
         if (pop_grp) rd_ff <= !rd_ff;
      end
   end

   `SBT_ASSERT_IMPL(a_no_push_full, clock, reset, push, !full && push_grp.count != 2'd0, "push into full queue or empty group")
   `SBT_ASSERT_IMPL(a_sub_in_group, clock, reset, rsp_valid, head.count != 2'd0 && sub_ff < head.count, "token index past group")
   `SBT_ASSERT_NEXT(a_group_drain, clock, reset, pop_grp && !push, fill_ff == $past(fill_ff) - 2'd1, "group pop lost")

endmodule

`default_nettype wire
